>>> rtl/core/great_circle_distance_assert.svh
// ============================================================================
// Great-circle distance assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is set.
// ============================================================================
`ifndef GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_ASSERT_SVH
`ifndef SYNTHESIS
// cond must hold at every clock edge out of reset
`define GCD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("great_circle_distance: invariant violated");
// post must hold in the cycle after pre
`define GCD_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("great_circle_distance: sequence violated");
`else
`define GCD_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define GCD_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

>>> rtl/core/gcd_pkg.sv
// ============================================================================
// Great-circle distance package
// Shared fixed-point types, constants and the arctangent table function.
// ============================================================================
package gcd_pkg;

    localparam int CW         = 34;   // CORDIC datapath width
    localparam int SQRT_STEPS = 31;   // one root bit per step, 61-bit radicand

    typedef logic [31:0]          phase_t;   // 2^-32 turn
    typedef logic signed [31:0]   trig_t;    // Q30
    typedef logic signed [CW-1:0] cordic_t;
    typedef logic [31:0]          angle_t;   // 2^-32 turn, unsigned

    localparam cordic_t             INV_GAIN    = 34'sd652032874;
    localparam logic signed [62:0]  DEG_TO_TURN = 63'sd640511947;
    localparam logic signed [62:0]  PHASE_ROUND = 63'sd268435456;
    localparam logic [28:0]         OUT_MAX     = 29'd536870911;

    localparam logic [1:0] UNIT_METERS   = 2'd1;
    localparam logic [1:0] UNIT_NAUTICAL = 2'd2;

    // restoring divide, elaboration use only
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        int              b;
        q   = 64'd0;
        rem = 64'd0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in 2^-32 turn, from the arctangent series
    function automatic cordic_t atan_entry(input int i);
        longint unsigned sum;
        longint unsigned term;
        longint unsigned rad;
        longint unsigned prod;
        int              k;
        sum = 64'd0;
        if (i == 0)
            return cordic_t'(64'd1 << 29);
        for (k = 0; i * (2 * k + 1) <= 62; k++)
        begin
            term = udiv64(64'd1 << (62 - i * (2 * k + 1)), longint'(2 * k + 1));
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        rad  = sum >> 30;
        prod = rad * 64'd683565276 + (64'd1 << 31);
        return cordic_t'(prod >> 32);
    endfunction

endpackage

>>> rtl/core/gcd_sincos.sv
// ============================================================================
// Pipelined sine/cosine
// Rotation-mode CORDIC, one iteration per register stage, quadrant fold.
// ============================================================================
module gcd_sincos #(
    parameter int STAGES = 24
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  gcd_pkg::phase_t phase,
    output logic           out_valid,
    output gcd_pkg::trig_t cos_out,
    output gcd_pkg::trig_t sin_out
);
    import gcd_pkg::*;

    cordic_t x_reg     [STAGES];
    cordic_t y_reg     [STAGES];
    cordic_t z_reg     [STAGES];
    logic    neg_reg   [STAGES];
    logic    valid_reg [STAGES];

    phase_t  fold_sum;
    logic    fold_neg;
    phase_t  folded;

    trig_t   cos_reg;
    trig_t   sin_reg;
    logic    out_valid_reg;

    // fold into [-1/4, 1/4) turn, negate at the end
    assign fold_sum = phase + 32'h4000_0000;
    assign fold_neg = fold_sum[31];
    assign folded   = {phase[31] ^ fold_neg, phase[30:0]};

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam cordic_t ATAN = atan_entry(i);
        cordic_t x_in;
        cordic_t y_in;
        cordic_t z_in;
        logic    neg_in;
        logic    valid_in;
        cordic_t x_next;
        cordic_t y_next;
        cordic_t z_next;

        if (i == 0)
        begin : g_first
            assign x_in     = INV_GAIN;
            assign y_in     = '0;
            assign z_in     = cordic_t'($signed(folded));
            assign neg_in   = fold_neg;
            assign valid_in = in_valid;
        end
        else
        begin : g_rest
            assign x_in     = x_reg[i-1];
            assign y_in     = y_reg[i-1];
            assign z_in     = z_reg[i-1];
            assign neg_in   = neg_reg[i-1];
            assign valid_in = valid_reg[i-1];
        end

        always_comb
        begin
            if (!z_in[CW-1])
            begin
                x_next = x_in - (y_in >>> i);
                y_next = y_in + (x_in >>> i);
                z_next = z_in - ATAN;
            end
            else
            begin
                x_next = x_in + (y_in >>> i);
                y_next = y_in - (x_in >>> i);
                z_next = z_in + ATAN;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en)
                valid_reg[i] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]   <= x_next;
                y_reg[i]   <= y_next;
                z_reg[i]   <= z_next;
                neg_reg[i] <= neg_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= valid_reg[STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= neg_reg[STAGES-1] ? trig_t'(-x_reg[STAGES-1])
                                         : trig_t'(x_reg[STAGES-1]);
            sin_reg <= neg_reg[STAGES-1] ? trig_t'(-y_reg[STAGES-1])
                                         : trig_t'(y_reg[STAGES-1]);
        end
    end

    assign out_valid = out_valid_reg;
    assign cos_out   = cos_reg;
    assign sin_out   = sin_reg;

endmodule

>>> rtl/core/gcd_acos.sv
// ============================================================================
// Pipelined arccosine
// Radicand, digit-by-digit square root, vectoring CORDIC and clamp.
// ============================================================================
module gcd_acos #(
    parameter int STAGES = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  gcd_pkg::trig_t  cos_in,
    output logic            out_valid,
    output gcd_pkg::angle_t angle
);
    import gcd_pkg::*;

    // radicand stage
    logic signed [63:0] csq;
    logic [60:0]        rad_reg;
    trig_t              c0_reg;
    logic               v0_reg;

    // square root stages
    logic [60:0] n_reg  [SQRT_STEPS];
    logic [61:0] r_reg  [SQRT_STEPS];
    trig_t       cs_reg [SQRT_STEPS];
    logic        vs_reg [SQRT_STEPS];

    // vectoring stages
    cordic_t x_reg  [STAGES];
    cordic_t y_reg  [STAGES];
    cordic_t z_reg  [STAGES];
    logic    vv_reg [STAGES];

    angle_t  angle_reg;
    logic    out_valid_reg;
    angle_t  angle_next;

    assign csq = 64'(cos_in) * 64'(cos_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= (61'd1 << 60) - csq[60:0];
            c0_reg  <= cos_in;
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * j);
        logic [60:0] n_in;
        logic [61:0] r_in;
        trig_t       c_in;
        logic        v_in;
        logic [61:0] trial;
        logic [60:0] n_next;
        logic [61:0] r_next;

        if (j == 0)
        begin : g_first
            assign n_in = rad_reg;
            assign r_in = '0;
            assign c_in = c0_reg;
            assign v_in = v0_reg;
        end
        else
        begin : g_rest
            assign n_in = n_reg[j-1];
            assign r_in = r_reg[j-1];
            assign c_in = cs_reg[j-1];
            assign v_in = vs_reg[j-1];
        end

        assign trial = r_in + BIT;

        always_comb
        begin
            if ({1'b0, n_in} >= trial)
            begin
                n_next = n_in - trial[60:0];
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                n_next = n_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vs_reg[j] <= 1'b0;
            else if (en)
                vs_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[j]  <= n_next;
                r_reg[j]  <= r_next;
                cs_reg[j] <= c_in;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_vec
        localparam cordic_t ATAN = atan_entry(i);
        cordic_t x_in;
        cordic_t y_in;
        cordic_t z_in;
        logic    v_in;
        cordic_t x_next;
        cordic_t y_next;
        cordic_t z_next;

        if (i == 0)
        begin : g_first
            trig_t   c_fin;
            cordic_t s_fin;
            assign c_fin = cs_reg[SQRT_STEPS-1];
            assign s_fin = cordic_t'({1'b0, r_reg[SQRT_STEPS-1][30:0]});
            // negative cosine: start a quarter turn on, vector is (s, -c)
            assign x_in  = c_fin[31] ? s_fin : cordic_t'(c_fin);
            assign y_in  = c_fin[31] ? -cordic_t'(c_fin) : s_fin;
            assign z_in  = c_fin[31] ? cordic_t'(64'd1 << 30) : '0;
            assign v_in  = vs_reg[SQRT_STEPS-1];
        end
        else
        begin : g_rest
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
            assign v_in = vv_reg[i-1];
        end

        always_comb
        begin
            if (!y_in[CW-1] && (|y_in))
            begin
                x_next = x_in + (y_in >>> i);
                y_next = y_in - (x_in >>> i);
                z_next = z_in + ATAN;
            end
            else
            begin
                x_next = x_in - (y_in >>> i);
                y_next = y_in + (x_in >>> i);
                z_next = z_in - ATAN;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vv_reg[i] <= 1'b0;
            else if (en)
                vv_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
            end
        end
    end

    // clamp residue to [0, half turn]
    always_comb
    begin
        if (z_reg[STAGES-1][CW-1])
            angle_next = '0;
        else if (z_reg[STAGES-1] > cordic_t'(64'd1 << 31))
            angle_next = 32'h8000_0000;
        else
            angle_next = z_reg[STAGES-1][31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vv_reg[STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= angle_next;
    end

    assign out_valid = out_valid_reg;
    assign angle     = angle_reg;

endmodule

>>> rtl/core/gcd_cdiv.sv
// ============================================================================
// Constant divider
// Floor division by a constant: split reciprocal multiply, then one
// remainder check that fixes the quotient low by one.
// ============================================================================
module gcd_cdiv #(
    parameter int WIDTH   = 36,
    parameter int DIVISOR = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] num,
    output logic             out_valid,
    output logic [WIDTH-1:0] quo
);
    localparam int LO = WIDTH / 2;
    localparam int HI = WIDTH - LO;
    localparam int PW = 2 * WIDTH;
    localparam longint unsigned RECIP_L = (64'd1 << WIDTH) / DIVISOR;
    localparam logic [WIDTH-1:0] RECIP  = WIDTH'(RECIP_L);
    localparam logic [WIDTH-1:0] DIV    = WIDTH'(DIVISOR);

    logic [HI+WIDTH-1:0] phi_reg;
    logic [LO+WIDTH-1:0] plo_reg;
    logic [WIDTH-1:0]    num1_reg;
    logic [WIDTH-1:0]    num2_reg;
    logic [WIDTH-1:0]    q0_reg;
    logic [WIDTH-1:0]    quo_reg;
    logic                v1_reg;
    logic                v2_reg;
    logic                v3_reg;

    logic [PW-1:0]       prod_sum;
    logic [WIDTH-1:0]    rem;

    assign prod_sum = (PW'(phi_reg) << LO) + PW'(plo_reg);
    assign rem      = num2_reg - WIDTH'(q0_reg * DIV);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phi_reg  <= (HI+WIDTH)'(num[WIDTH-1:LO]) * (HI+WIDTH)'(RECIP);
            plo_reg  <= (LO+WIDTH)'(num[LO-1:0]) * (LO+WIDTH)'(RECIP);
            num1_reg <= num;
            q0_reg   <= prod_sum[PW-1:WIDTH];
            num2_reg <= num1_reg;
            quo_reg  <= q0_reg + WIDTH'(rem >= DIV);
        end
    end

    assign out_valid = v3_reg;
    assign quo       = quo_reg;

endmodule

>>> rtl/core/great_circle_distance.sv
// ============================================================================
// Great-circle distance
// Law-of-cosines range between two positions, in 1/16 of a selected unit.
// ============================================================================
// Fully pipelined: one position pair per cycle while the pipeline is not held.
// The depth comes mostly from the sine/cosine CORDIC chain, the 31-step square
// root and the vectoring CORDIC of the arccosine, one register per iteration.
// A two-entry output buffer lets the pipeline keep running while one result
// waits; the whole pipeline holds only when both entries are full. unit_select
// must be written while no item is in flight.
`include "great_circle_distance_assert.svh"

module great_circle_distance #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    // cfg_data: unit_select[1:0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_data,
    // s_tdata: from_latitude[30:0], from_longitude[62:31],
    //          to_latitude[93:63], to_longitude[125:94], zero pad
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,
    // m_tdata: range_sixteenths[28:0], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata
);
    import gcd_pkg::*;

    logic        en;
    logic [1:0]  unit_select_reg;

    logic signed [30:0] from_latitude;
    logic signed [31:0] from_longitude;
    logic signed [30:0] to_latitude;
    logic signed [31:0] to_longitude;

    // phase stages
    logic signed [62:0] plat1_reg, plon1_reg, plat2_reg, plon2_reg;
    logic               va_reg;
    logic signed [62:0] rlat1, rlon1, rlat2, rlon2;
    phase_t             ph_lat1_reg, ph_lat2_reg, ph_dlon_reg;
    logic               vb_reg;

    // trig outputs
    trig_t c1, s1, c2, s2, ct;
    logic  vt1, vt2, vt3;

    // cosine combine
    logic signed [63:0] ss_reg, cc_reg;
    trig_t              ct_reg;
    logic signed [65:0] ss2_reg, p_reg;
    logic signed [33:0] cch;
    logic signed [65:0] csum;
    logic signed [35:0] cq;
    trig_t              cos_next;
    trig_t              cos_reg;
    logic               vc1_reg, vc2_reg, vc3_reg;

    // scaling
    angle_t       z;
    logic         vz;
    logic [47:0]  w;
    logic [35:0]  v5_reg;
    logic         vk1_reg;
    logic         vm5;
    logic [35:0]  q5;
    logic [33:0]  m;
    logic [47:0]  wm, wn;
    logic [34:0]  wmi;
    logic [35:0]  vm_reg;
    logic [27:0]  vn_reg;
    logic [18:0]  mi_reg;
    logic [18:0]  mi_pipe_reg [3];
    logic         vk2_reg;
    logic         vqm, vqn;
    logic [35:0]  qm;
    logic [27:0]  qn;
    logic         end_valid;
    logic [35:0]  sel;
    logic [28:0]  result;

    // output buffer
    logic        main_valid_reg, spare_valid_reg;
    logic [28:0] main_reg, spare_reg;
    logic        pop, push;

    assign from_latitude  = s_tdata[30:0];
    assign from_longitude = s_tdata[62:31];
    assign to_latitude    = s_tdata[93:63];
    assign to_longitude   = s_tdata[125:94];

    assign en        = !spare_valid_reg;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            unit_select_reg <= 2'd0;
        else if (cfg_valid)
            unit_select_reg <= cfg_data;
    end

    // --- degrees to turn phase ---
    assign rlat1 = plat1_reg + PHASE_ROUND;
    assign rlon1 = plon1_reg + PHASE_ROUND;
    assign rlat2 = plat2_reg + PHASE_ROUND;
    assign rlon2 = plon2_reg + PHASE_ROUND;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plat1_reg   <= 63'(from_latitude) * DEG_TO_TURN;
            plon1_reg   <= 63'(from_longitude) * DEG_TO_TURN;
            plat2_reg   <= 63'(to_latitude) * DEG_TO_TURN;
            plon2_reg   <= 63'(to_longitude) * DEG_TO_TURN;
            ph_lat1_reg <= rlat1[60:29];
            ph_lat2_reg <= rlat2[60:29];
            ph_dlon_reg <= rlon1[60:29] - rlon2[60:29];
        end
    end

    gcd_sincos #(.STAGES(CORDIC_STAGES)) u_trig_lat1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vb_reg),
        .phase     (ph_lat1_reg),
        .out_valid (vt1),
        .cos_out   (c1),
        .sin_out   (s1)
    );

    gcd_sincos #(.STAGES(CORDIC_STAGES)) u_trig_lat2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vb_reg),
        .phase     (ph_lat2_reg),
        .out_valid (vt2),
        .cos_out   (c2),
        .sin_out   (s2)
    );

    gcd_sincos #(.STAGES(CORDIC_STAGES)) u_trig_dlon (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vb_reg),
        .phase     (ph_dlon_reg),
        .out_valid (vt3),
        .cos_out   (ct),
        .sin_out   ()
    );

    // --- cosine of central angle ---
    assign cch  = cc_reg[63:30];
    assign csum = ss2_reg + p_reg + 66'sd536870912;
    assign cq   = csum[65:30];

    always_comb
    begin
        if (cq > 36'sd1073741824)
            cos_next = 32'sd1073741824;
        else if (cq < -36'sd1073741824)
            cos_next = -32'sd1073741824;
        else
            cos_next = cq[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc1_reg <= 1'b0;
            vc2_reg <= 1'b0;
            vc3_reg <= 1'b0;
        end
        else if (en)
        begin
            vc1_reg <= vt1 & vt2 & vt3;
            vc2_reg <= vc1_reg;
            vc3_reg <= vc2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ss_reg  <= 64'(s1) * 64'(s2);
            cc_reg  <= 64'(c1) * 64'(c2);
            ct_reg  <= ct;
            ss2_reg <= 66'(ss_reg);
            p_reg   <= 66'(cch) * 66'(ct_reg);
            cos_reg <= cos_next;
        end
    end

    gcd_acos #(.STAGES(CORDIC_STAGES)) u_acos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vc3_reg),
        .cos_in    (cos_reg),
        .out_valid (vz),
        .angle     (z)
    );

    // --- angle to 1/16 mile, Q16: m = floor((z*62181 + 5120) / 2^11 / 5) ---
    assign w = 48'(z) * 48'd62181 + 48'd5120;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vk1_reg <= 1'b0;
        else if (en)
            vk1_reg <= vz;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            v5_reg <= w[46:11];
    end

    gcd_cdiv #(.WIDTH(36), .DIVISOR(5)) u_div5 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vk1_reg),
        .num       (v5_reg),
        .out_valid (vm5),
        .quo       (q5)
    );

    // unit scaling with common factors of 2 pulled into the shifts
    assign m   = q5[33:0];
    assign wm  = 48'(m) * 48'd12573 + 48'd256000;
    assign wn  = 48'(m) * 48'd2171 + 48'd81920000;
    assign wmi = 35'(m) + 35'd32768;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vk2_reg <= 1'b0;
        else if (en)
            vk2_reg <= vm5;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vm_reg         <= wm[47:12];
            vn_reg         <= wn[45:18];
            mi_reg         <= wmi[34:16];
            mi_pipe_reg[0] <= mi_reg;
            mi_pipe_reg[1] <= mi_pipe_reg[0];
            mi_pipe_reg[2] <= mi_pipe_reg[1];
        end
    end

    gcd_cdiv #(.WIDTH(36), .DIVISOR(125)) u_div_meters (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vk2_reg),
        .num       (vm_reg),
        .out_valid (vqm),
        .quo       (qm)
    );

    gcd_cdiv #(.WIDTH(28), .DIVISOR(625)) u_div_nautical (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vk2_reg),
        .num       (vn_reg),
        .out_valid (vqn),
        .quo       (qn)
    );

    assign end_valid = vqm & vqn;

    always_comb
    begin
        case (unit_select_reg)
            UNIT_METERS:   sel = qm;
            UNIT_NAUTICAL: sel = 36'(qn);
            default:       sel = 36'(mi_pipe_reg[2]);
        endcase
    end

    assign result = (sel > 36'(OUT_MAX)) ? OUT_MAX : sel[28:0];

    // --- two-entry output buffer ---
    assign pop  = main_valid_reg & m_tready;
    assign push = end_valid & en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (spare_valid_reg)
        begin
            if (pop)
                spare_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                spare_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (spare_valid_reg)
        begin
            if (pop)
                main_reg <= spare_reg;
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                spare_reg <= result;
            else
                main_reg <= result;
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {3'b000, main_reg};

    `GCD_ASSERT_ALWAYS(a_spare_needs_main, clk, rst_n, !spare_valid_reg || main_valid_reg)
    `GCD_ASSERT_NEXT(a_spare_drains, clk, rst_n, spare_valid_reg && m_tready, main_valid_reg && !spare_valid_reg)
    `GCD_ASSERT_NEXT(a_stall_fills_spare, clk, rst_n, main_valid_reg && !m_tready && !spare_valid_reg && end_valid, spare_valid_reg)

endmodule
